// ===== rtl/krs_pkg.sv =====
package krs_pkg;

	// action codes carried by an input item
	localparam logic [2:0] ACT_ADD_START = 3'd0;
	localparam logic [2:0] ACT_ADD_DATA  = 3'd1;
	localparam logic [2:0] ACT_DELETE    = 3'd2;
	localparam logic [2:0] ACT_FIND      = 3'd3;
	localparam logic [2:0] ACT_CLEAR     = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;

	// largest length a find header can report
	localparam logic [7:0] HDR_LEN_MAX = 8'd63;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FILL,
		S_WALK,
		S_KEY,
		S_LEN,
		S_MOVE,
		S_HDR,
		S_FRD,
		S_FOUT,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_DECODE,
		OP_FILL,
		OP_WALK,
		OP_KEY,
		OP_LEN,
		OP_MOVE,
		OP_HDR,
		OP_FRD,
		OP_FOUT,
		OP_RESP
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] act;
		logic       add_reject;
		logic       data_reject;
		logic       walk_end;
		logic       key_match;
		logic       fill_done;
		logic       move_done;
		logic       flen_zero;
		logic       fout_last;
		logic       out_free;
	} dp_stat_t;

endpackage

// ===== rtl/krs_ctrl.sv =====
module krs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  krs_pkg::dp_stat_t  stat,
	output krs_pkg::dp_cmd_t   cmd
);

	krs_pkg::state_t state_q, state_d;
	logic [1:0]      code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krs_pkg::S_IDLE;
			code_q  <= krs_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		unique case (state_q)
			krs_pkg::S_IDLE: begin
				if (in_valid) state_d = krs_pkg::S_DECODE;
			end
			krs_pkg::S_DECODE: begin
				unique case (stat.act)
					krs_pkg::ACT_ADD_START: begin
						if (stat.add_reject) begin
							state_d = krs_pkg::S_RESP;
							code_d  = krs_pkg::ST_TOO_LARGE;
						end else begin
							state_d = krs_pkg::S_FILL;
						end
					end
					krs_pkg::ACT_ADD_DATA: begin
						state_d = krs_pkg::S_RESP;
						code_d  = stat.data_reject ? krs_pkg::ST_NOT_FOUND : krs_pkg::ST_OK;
					end
					krs_pkg::ACT_DELETE, krs_pkg::ACT_FIND: begin
						state_d = krs_pkg::S_WALK;
					end
					krs_pkg::ACT_CLEAR: begin
						state_d = krs_pkg::S_RESP;
						code_d  = krs_pkg::ST_OK;
					end
					default: begin
						// unused codes produce nothing
						state_d = krs_pkg::S_IDLE;
					end
				endcase
			end
			krs_pkg::S_FILL: begin
				if (stat.fill_done) begin
					state_d = krs_pkg::S_RESP;
					code_d  = krs_pkg::ST_OK;
				end
			end
			krs_pkg::S_WALK: begin
				if (stat.walk_end) begin
					state_d = krs_pkg::S_RESP;
					code_d  = krs_pkg::ST_NOT_FOUND;
				end else begin
					state_d = krs_pkg::S_KEY;
				end
			end
			krs_pkg::S_KEY: begin
				state_d = krs_pkg::S_LEN;
			end
			krs_pkg::S_LEN: begin
				priority if (!stat.key_match) state_d = krs_pkg::S_WALK;
				else if (stat.act == krs_pkg::ACT_DELETE) state_d = krs_pkg::S_MOVE;
				else state_d = krs_pkg::S_HDR;
			end
			krs_pkg::S_MOVE: begin
				if (stat.move_done) begin
					state_d = krs_pkg::S_RESP;
					code_d  = krs_pkg::ST_OK;
				end
			end
			krs_pkg::S_HDR: begin
				if (stat.out_free)
					state_d = stat.flen_zero ? krs_pkg::S_IDLE : krs_pkg::S_FRD;
			end
			krs_pkg::S_FRD: begin
				state_d = krs_pkg::S_FOUT;
			end
			krs_pkg::S_FOUT: begin
				if (stat.out_free)
					state_d = stat.fout_last ? krs_pkg::S_IDLE : krs_pkg::S_FRD;
			end
			krs_pkg::S_RESP: begin
				if (stat.out_free) state_d = krs_pkg::S_IDLE;
			end
			default: begin
				state_d = krs_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == krs_pkg::S_IDLE);
		cmd.code = code_q;
		cmd.op   = krs_pkg::OP_NONE;
		unique case (state_q)
			krs_pkg::S_IDLE:   cmd.op = in_valid ? krs_pkg::OP_LATCH : krs_pkg::OP_NONE;
			krs_pkg::S_DECODE: cmd.op = krs_pkg::OP_DECODE;
			krs_pkg::S_FILL:   cmd.op = krs_pkg::OP_FILL;
			krs_pkg::S_WALK:   cmd.op = krs_pkg::OP_WALK;
			krs_pkg::S_KEY:    cmd.op = krs_pkg::OP_KEY;
			krs_pkg::S_LEN:    cmd.op = krs_pkg::OP_LEN;
			krs_pkg::S_MOVE:   cmd.op = krs_pkg::OP_MOVE;
			krs_pkg::S_HDR:    cmd.op = stat.out_free ? krs_pkg::OP_HDR : krs_pkg::OP_NONE;
			krs_pkg::S_FRD:    cmd.op = krs_pkg::OP_FRD;
			krs_pkg::S_FOUT:   cmd.op = stat.out_free ? krs_pkg::OP_FOUT : krs_pkg::OP_NONE;
			krs_pkg::S_RESP:   cmd.op = stat.out_free ? krs_pkg::OP_RESP : krs_pkg::OP_NONE;
			default:           cmd.op = krs_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/krs_dp.sv =====
module krs_dp #(
	parameter int STORE_BYTES = 256,
	parameter int MAX_PAYLOAD = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  krs_pkg::dp_cmd_t   cmd,
	output krs_pkg::dp_stat_t  stat,
	input  logic [2:0]         action,
	input  logic [7:0]         key,
	input  logic [5:0]         record_length,
	input  logic [7:0]         data_byte,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [5:0]         found_length,
	output logic [7:0]         payload_byte,
	output logic               is_payload,
	output logic               last
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int UW = $clog2(STORE_BYTES + 1);
	// walk pointer may step past the end by up to a full record
	localparam int PW = $clog2(STORE_BYTES + 258);
	localparam logic [PW-1:0] StoreLim = PW'(STORE_BYTES);
	localparam logic [7:0]    MaxPay   = 8'(MAX_PAYLOAD);

	logic [7:0] mem [STORE_BYTES];

	logic [2:0]    act_q;
	logic [7:0]    key_q;
	logic [5:0]    rlen_q;
	logic [7:0]    dbyte_q;
	logic [UW-1:0] used_q;
	logic [5:0]    pse_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] aux_q;
	logic [6:0]    cnt_q;
	logic          match_q;
	logic          endhit_q;
	logic          pend_q;
	logic [5:0]    flen_q;
	logic [7:0]    rd_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [5:0]    flen_out_q;
	logic [7:0]    pbyte_q;
	logic          isp_q;
	logic          last_q;

	logic [PW-1:0] used_p;
	logic [PW-1:0] ptr1;
	logic [PW-1:0] len_step;
	logic [PW-1:0] add_need;
	logic [PW-1:0] dpos;
	logic [PW-1:0] avail;
	logic [5:0]    len_cap;
	logic [5:0]    flen_next;
	logic          add_reject;
	logic          data_reject;
	logic          walk_end;
	logic          src_more;
	logic          move_done;
	logic          fill_done;
	logic          out_free;
	logic          out_load;
	logic [7:0]    fill_byte;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	assign used_p      = PW'(used_q);
	assign ptr1        = ptr_q + PW'(1);
	assign len_step    = ptr_q + PW'(rd_q) + PW'(2);
	assign add_need    = used_p + PW'(rlen_q) + PW'(2);
	assign dpos        = used_p - PW'(pse_q);
	assign avail       = used_p - (ptr_q + PW'(2));
	assign len_cap     = (rd_q > krs_pkg::HDR_LEN_MAX) ? 6'd63 : rd_q[5:0];
	assign flen_next   = (PW'(len_cap) > avail) ? avail[5:0] : len_cap;
	assign add_reject  = ({2'b00, rlen_q} > MaxPay) || (add_need > StoreLim);
	assign data_reject = (pse_q == 6'd0) || (PW'(pse_q) > used_p);
	assign walk_end    = !((ptr1 < used_p) && (ptr1 < StoreLim));
	assign src_more    = (aux_q < used_p);
	assign move_done   = !src_more && !pend_q;
	assign fill_done   = (cnt_q == ({1'b0, rlen_q} + 7'd1));
	assign out_free    = !out_valid_q || out_ready;
	assign out_load    = (cmd.op == krs_pkg::OP_HDR) || (cmd.op == krs_pkg::OP_FOUT) ||
	                     (cmd.op == krs_pkg::OP_RESP);

	// record is written as key, length, then zeroed payload slots
	always_comb begin
		priority if (cnt_q == 7'd0) fill_byte = key_q;
		else if (cnt_q == 7'd1) fill_byte = {2'b00, rlen_q};
		else fill_byte = 8'd0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = 8'd0;
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (cmd.op)
			krs_pkg::OP_DECODE: begin
				if (act_q == krs_pkg::ACT_ADD_DATA && !data_reject) begin
					mem_we = 1'b1;
					mem_wa = dpos[AW-1:0];
					mem_wd = dbyte_q;
				end
			end
			krs_pkg::OP_FILL: begin
				mem_we = 1'b1;
				mem_wa = aux_q[AW-1:0];
				mem_wd = fill_byte;
			end
			krs_pkg::OP_WALK: begin
				mem_re = !walk_end;
				mem_ra = ptr_q[AW-1:0];
			end
			krs_pkg::OP_KEY: begin
				mem_re = 1'b1;
				mem_ra = ptr1[AW-1:0];
			end
			krs_pkg::OP_MOVE: begin
				// read runs one byte ahead of the write
				mem_re = src_more;
				mem_ra = aux_q[AW-1:0];
				mem_we = pend_q;
				mem_wa = ptr_q[AW-1:0];
				mem_wd = rd_q;
			end
			krs_pkg::OP_FRD: begin
				mem_re = 1'b1;
				mem_ra = aux_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			pse_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				krs_pkg::OP_DECODE: begin
					unique case (act_q)
						krs_pkg::ACT_ADD_START: pse_q <= 6'd0;
						krs_pkg::ACT_ADD_DATA: begin
							if (!data_reject) pse_q <= pse_q - 6'd1;
						end
						krs_pkg::ACT_CLEAR: begin
							used_q <= '0;
							pse_q  <= 6'd0;
						end
						default: begin
						end
					endcase
				end
				krs_pkg::OP_FILL: begin
					if (fill_done) begin
						used_q <= add_need[UW-1:0];
						pse_q  <= rlen_q;
					end
				end
				krs_pkg::OP_MOVE: begin
					if (move_done) begin
						used_q <= ptr_q[UW-1:0];
						if (endhit_q) pse_q <= 6'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			krs_pkg::OP_LATCH: begin
				act_q   <= action;
				key_q   <= key;
				rlen_q  <= record_length;
				dbyte_q <= data_byte;
			end
			krs_pkg::OP_DECODE: begin
				aux_q <= used_p;
				cnt_q <= 7'd0;
				ptr_q <= '0;
			end
			krs_pkg::OP_FILL: begin
				aux_q <= aux_q + PW'(1);
				cnt_q <= cnt_q + 7'd1;
			end
			krs_pkg::OP_KEY: begin
				match_q <= (rd_q == key_q);
			end
			krs_pkg::OP_LEN: begin
				if (match_q) begin
					pend_q   <= 1'b0;
					endhit_q <= (len_step >= used_p);
					flen_q   <= flen_next;
					cnt_q    <= {1'b0, flen_next};
					if (act_q == krs_pkg::ACT_DELETE)
						aux_q <= (len_step < used_p) ? len_step : used_p;
					else
						aux_q <= ptr_q + PW'(2);
				end else begin
					ptr_q <= len_step;
				end
			end
			krs_pkg::OP_MOVE: begin
				if (src_more) aux_q <= aux_q + PW'(1);
				pend_q <= src_more;
				if (pend_q) ptr_q <= ptr_q + PW'(1);
			end
			krs_pkg::OP_FRD: begin
				aux_q <= aux_q + PW'(1);
			end
			krs_pkg::OP_FOUT: begin
				cnt_q <= cnt_q - 7'd1;
			end
			default: begin
			end
		endcase

		unique case (cmd.op)
			krs_pkg::OP_HDR: begin
				status_q   <= krs_pkg::ST_OK;
				flen_out_q <= flen_q;
				pbyte_q    <= 8'd0;
				isp_q      <= 1'b0;
				last_q     <= (flen_q == 6'd0);
			end
			krs_pkg::OP_FOUT: begin
				status_q   <= krs_pkg::ST_OK;
				flen_out_q <= 6'd0;
				pbyte_q    <= rd_q;
				isp_q      <= 1'b1;
				last_q     <= (cnt_q == 7'd1);
			end
			krs_pkg::OP_RESP: begin
				status_q   <= cmd.code;
				flen_out_q <= 6'd0;
				pbyte_q    <= 8'd0;
				isp_q      <= 1'b0;
				last_q     <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.act         = act_q;
	assign stat.add_reject  = add_reject;
	assign stat.data_reject = data_reject;
	assign stat.walk_end    = walk_end;
	assign stat.key_match   = match_q;
	assign stat.fill_done   = fill_done;
	assign stat.move_done   = move_done;
	assign stat.flen_zero   = (flen_q == 6'd0);
	assign stat.fout_last   = (cnt_q == 7'd1);
	assign stat.out_free    = out_free;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_length = flen_out_q;
	assign payload_byte = pbyte_q;
	assign is_payload   = isp_q;
	assign last         = last_q;

endmodule

// ===== rtl/keyed_record_store.sv =====
// Keyed record store: records of key, length and payload bytes packed in a single-port-write,
// single-port-read byte memory of STORE_BYTES entries. One item is worked on at a time; the
// next is taken once the last result of the current one sits in the output register. An
// add_start makes one memory write per byte of the new record; find and delete walk the
// records with a key read, a length read and a step for each record passed, then delete
// compacts at one byte a cycle over every byte behind the removed record, and find returns a
// header and then the payload bytes, each read from memory before it is loaded into the
// output register, stalling while out_ready is low.
module keyed_record_store #(
	parameter int STORE_BYTES = 256,
	parameter int MAX_PAYLOAD = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [7:0] key,
	input  logic [5:0] record_length,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [5:0] found_length,
	output logic [7:0] payload_byte,
	output logic       is_payload,
	output logic       last
);

	krs_pkg::dp_cmd_t  cmd;
	krs_pkg::dp_stat_t stat;

	krs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	krs_dp #(
		.STORE_BYTES (STORE_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (action),
		.key           (key),
		.record_length (record_length),
		.data_byte     (data_byte),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.found_length  (found_length),
		.payload_byte  (payload_byte),
		.is_payload    (is_payload),
		.last          (last)
	);

endmodule

// ===== tb/keyed_record_store_test.sv =====
`timescale 1ns / 1ps

module keyed_record_store_test;

	localparam int STORE_BYTES = 256;
	localparam int MAX_PAYLOAD = 63;
	// action codes the block ignores
	localparam logic [2:0] ACT_SPARE_FIRST = krs_pkg::ACT_CLEAR + 3'd1;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam int HOLD_AT     = 80;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0] act;
		logic [7:0] key;
		logic [5:0] rlen;
		logic [7:0] dbyte;
	} item_t;

	typedef struct packed {
		logic [1:0] st;
		logic [5:0] flen;
		logic [7:0] pbyte;
		logic       isp;
		logic       lst;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] action = '0;
	logic [7:0] key = '0;
	logic [5:0] record_length = '0;
	logic [7:0] data_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [5:0] found_length;
	logic [7:0] payload_byte;
	logic       is_payload;
	logic       last;

	item_t   pending[$];
	result_t want_q[$];
	int      offered = 0;
	int      taken = 0;
	int      mismatches = 0;
	int      hold_left = 0;
	bit      hold_done = 0;
	logic    calm;

	// predictor state
	logic [7:0] store_image [STORE_BYTES];
	int         used_bytes = 0;
	int         fill_left = 0;
	logic [7:0] key_pool [8];

	keyed_record_store #(
		.STORE_BYTES(STORE_BYTES),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.key(key),
		.record_length(record_length),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_length(found_length),
		.payload_byte(payload_byte),
		.is_payload(is_payload),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// no idling on either side for a stretch of items
	assign calm = taken >= 200 && taken < 260;

	task automatic note_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_result(input logic [1:0] st, input int flen, input logic [7:0] pb,
		input logic isp, input logic lst);
		result_t r;
		r.st = st;
		r.flen = 6'(flen);
		r.pbyte = pb;
		r.isp = isp;
		r.lst = lst;
		want_q.push_back(r);
	endtask

	// first record with this key, walking from address 0
	function automatic bit seek_key(input logic [7:0] k, output int at);
		int i;
		i = 0;
		at = 0;
		while (i + 1 < used_bytes && i + 1 < STORE_BYTES) begin
			if (store_image[i] == k) begin
				at = i;
				return 1'b1;
			end
			i = i + int'(store_image[i + 1]) + 2;
		end
		return 1'b0;
	endfunction

	task automatic predict_item(input item_t it);
		int at, tail, flen, pos;
		case (it.act)
			krs_pkg::ACT_ADD_START: begin
				fill_left = 0;
				if (it.rlen > MAX_PAYLOAD || it.rlen + 2 + used_bytes > STORE_BYTES) begin
					queue_result(krs_pkg::ST_TOO_LARGE, 0, 8'd0, 1'b0, 1'b1);
				end else begin
					store_image[used_bytes] = it.key;
					store_image[used_bytes + 1] = 8'(it.rlen);
					for (int j = 0; j < it.rlen; j++)
						store_image[used_bytes + 2 + j] = 8'd0;
					used_bytes += it.rlen + 2;
					fill_left = it.rlen;
					queue_result(krs_pkg::ST_OK, 0, 8'd0, 1'b0, 1'b1);
				end
			end
			krs_pkg::ACT_ADD_DATA: begin
				if (fill_left == 0 || fill_left > used_bytes) begin
					queue_result(krs_pkg::ST_NOT_FOUND, 0, 8'd0, 1'b0, 1'b1);
				end else begin
					pos = used_bytes - fill_left;
					if (pos < STORE_BYTES)
						store_image[pos] = it.dbyte;
					fill_left--;
					queue_result(krs_pkg::ST_OK, 0, 8'd0, 1'b0, 1'b1);
				end
			end
			krs_pkg::ACT_DELETE: begin
				if (!seek_key(it.key, at)) begin
					queue_result(krs_pkg::ST_NOT_FOUND, 0, 8'd0, 1'b0, 1'b1);
				end else begin
					tail = at + int'(store_image[at + 1]) + 2;
					if (tail > used_bytes)
						tail = used_bytes;
					// removing the record still being filled closes it
					if (tail == used_bytes)
						fill_left = 0;
					for (int j = 0; j < used_bytes - tail; j++)
						store_image[at + j] = store_image[tail + j];
					used_bytes -= tail - at;
					queue_result(krs_pkg::ST_OK, 0, 8'd0, 1'b0, 1'b1);
				end
			end
			krs_pkg::ACT_FIND: begin
				if (!seek_key(it.key, at)) begin
					queue_result(krs_pkg::ST_NOT_FOUND, 0, 8'd0, 1'b0, 1'b1);
				end else begin
					flen = int'(store_image[at + 1]);
					if (flen > int'(krs_pkg::HDR_LEN_MAX))
						flen = int'(krs_pkg::HDR_LEN_MAX);
					if (at + 2 + flen > used_bytes)
						flen = used_bytes - (at + 2);
					queue_result(krs_pkg::ST_OK, flen, 8'd0, 1'b0, flen == 0);
					for (int j = 0; j < flen; j++)
						queue_result(krs_pkg::ST_OK, 0, store_image[at + 2 + j], 1'b1,
							j + 1 == flen);
				end
			end
			krs_pkg::ACT_CLEAR: begin
				used_bytes = 0;
				fill_left = 0;
				queue_result(krs_pkg::ST_OK, 0, 8'd0, 1'b0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	function automatic item_t mk(input logic [2:0] a, input logic [7:0] k,
		input logic [5:0] n, input logic [7:0] d);
		item_t it;
		it.act = a;
		it.key = k;
		it.rlen = n;
		it.dbyte = d;
		return it;
	endfunction

	// mostly well-formed add sequences on a small key set, plus lookups and noise
	task automatic add_random_items(input int n);
		int made, r, len, keep;
		logic [7:0] k;
		logic [2:0] a;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 9) == 0) ? 8'($urandom) : key_pool[$urandom_range(0, 7)];
			if (r < 40) begin
				r = $urandom_range(0, 99);
				len = r < 80 ? $urandom_range(0, 6) :
					r < 97 ? $urandom_range(7, 20) : $urandom_range(21, MAX_PAYLOAD);
				keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
				pending.push_back(mk(krs_pkg::ACT_ADD_START, k, 6'(len), 8'($urandom)));
				for (int j = 0; j < keep; j++)
					pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'($urandom), 6'($urandom),
						8'($urandom)));
				made += keep + 1;
			end else if (r < 65) begin
				pending.push_back(mk(krs_pkg::ACT_FIND, k, 6'($urandom), 8'($urandom)));
				made++;
			end else if (r < 80) begin
				pending.push_back(mk(krs_pkg::ACT_DELETE, k, 6'($urandom), 8'($urandom)));
				made++;
			end else if (r < 83) begin
				pending.push_back(mk(krs_pkg::ACT_CLEAR, k, 6'($urandom), 8'($urandom)));
				made++;
			end else begin
				a = 3'($urandom_range(0, 7));
				pending.push_back(mk(a, 8'($urandom), 6'($urandom), 8'($urandom)));
				if (a <= krs_pkg::ACT_CLEAR)
					made++;
			end
		end
	endtask

	task automatic wait_all_done();
		while (pending.size() != 0 || taken != offered || want_q.size() != 0)
			@(posedge clk);
	endtask

	// sender: one item per handshake, random gaps between items
	always @(negedge clk) begin : send_side
		item_t nx;
		if (arst_n) begin
			if (in_valid && taken != offered) begin
				// hold the current item until it is taken
			end else if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
				nx = pending.pop_front();
				action <= nx.act;
				key <= nx.key;
				record_length <= nx.rlen;
				data_byte <= nx.dbyte;
				in_valid <= 1'b1;
				offered <= offered + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls and one long hold-off while the sender keeps going
	always @(negedge clk) begin : recv_side
		if (!hold_done && taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(0, 99) >= 36;
		end
	end

	always @(posedge clk) begin : watch
		result_t got, want;
		item_t it;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.st = status;
				got.flen = found_length;
				got.pbyte = payload_byte;
				got.isp = is_payload;
				got.lst = last;
				if (want_q.size() == 0) begin
					note_mismatch($sformatf(
						"unexpected result st=%0d len=%0d byte=%02h pay=%0b last=%0b",
						got.st, got.flen, got.pbyte, got.isp, got.lst));
				end else begin
					want = want_q.pop_front();
					if (got !== want)
						note_mismatch($sformatf({
							"got st=%0d len=%0d byte=%02h pay=%0b last=%0b, ",
							"want st=%0d len=%0d byte=%02h pay=%0b last=%0b"},
							got.st, got.flen, got.pbyte, got.isp, got.lst,
							want.st, want.flen, want.pbyte, want.isp, want.lst));
				end
			end
			if (in_valid && in_ready) begin
				it.act = action;
				it.key = key;
				it.rlen = record_length;
				it.dbyte = data_byte;
				predict_item(it);
				taken <= taken + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < STORE_BYTES; i++)
			store_image[i] = 8'd0;
		for (int i = 0; i < 8; i++)
			key_pool[i] = 8'($urandom);
		key_pool[0] = 8'h00;
		key_pool[1] = 8'hFF;

		// empty store: lookups miss, stray data has no open record
		pending.push_back(mk(krs_pkg::ACT_CLEAR, 8'h00, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_FIND, 8'h00, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_DELETE, 8'hFF, 6'd63, 8'hFF));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'hFF));
		// largest record, partly filled, then found while still open
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'hFF, 6'd63, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'hFF));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'hFF, 6'd63, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'hA5));
		pending.push_back(mk(krs_pkg::ACT_FIND, 8'hFF, 6'd0, 8'h00));
		// new add closes the open one; third large record brings the store to 195 bytes
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'h00, 6'd63, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'h5A, 6'd63, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'h11, 6'd63, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'h3C));
		// exact fit to the last byte
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'h22, 6'd59, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'h77));
		// remove a middle record under the open one, keep filling after compaction
		pending.push_back(mk(krs_pkg::ACT_DELETE, 8'h00, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'h88));
		pending.push_back(mk(krs_pkg::ACT_FIND, 8'h22, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_DELETE, 8'h22, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_ADD_DATA, 8'h00, 6'd0, 8'h99));
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			pending.push_back(mk(3'(a), 8'hFF, 6'd63, 8'hFF));
		pending.push_back(mk(krs_pkg::ACT_FIND, 8'hFF, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_CLEAR, 8'hFF, 6'd63, 8'hFF));
		pending.push_back(mk(krs_pkg::ACT_ADD_START, 8'h01, 6'd0, 8'h00));
		pending.push_back(mk(krs_pkg::ACT_FIND, 8'h01, 6'd0, 8'h00));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender pauses until the block has drained between chunks
		wait_all_done();
		add_random_items(120);
		wait_all_done();
		add_random_items(120);
		wait_all_done();
		add_random_items(110);
		wait_all_done();
		repeat (400) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/krs_pkg.sv
rtl/krs_ctrl.sv
rtl/krs_dp.sv
rtl/keyed_record_store.sv
tb/keyed_record_store_test.sv
